FILE: hdl/dcts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcts_pkg
// shared types and codes for the dma chain tag address stepper
// ----------------------------------------------------------------------------
package dcts_pkg;

  // command codes
  localparam logic [2:0] CMD_WRITE_MADR  = 3'd0;
  localparam logic [2:0] CMD_WRITE_TADR  = 3'd1;
  localparam logic [2:0] CMD_TAG_STEP    = 3'd2;
  localparam logic [2:0] CMD_DATA_DONE   = 3'd3;
  localparam logic [2:0] CMD_WRITE_DEPTH = 3'd4;

  // chain tag kinds
  localparam logic [2:0] KIND_REFE = 3'd0;
  localparam logic [2:0] KIND_CNT  = 3'd1;
  localparam logic [2:0] KIND_NEXT = 3'd2;
  localparam logic [2:0] KIND_REF  = 3'd3;
  localparam logic [2:0] KIND_REFS = 3'd4;
  localparam logic [2:0] KIND_CALL = 3'd5;
  localparam logic [2:0] KIND_RET  = 3'd6;
  localparam logic [2:0] KIND_END  = 3'd7;

  localparam logic [1:0] MODE_CHAIN = 2'd1;

  localparam logic [31:0] QW_BYTES = 32'd16;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  tag_id;
    logic [15:0] quadword_count;
    logic [31:0] write_value;
    logic        channel_started;
    logic [1:0]  channel_mode;
    logic [2:0]  last_tag_id;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] memory_address;
    logic [31:0] tag_address;
    logic [1:0]  stack_depth;
    logic        end_transfer;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] mem_addr;
    logic [31:0] next_tag_addr;
    logic [31:0] return_slot0;
    logic [31:0] return_slot1;
    logic [1:0]  depth_count;
  } chan_state_t;

endpackage

FILE: hdl/dma_chain_tag_address_stepper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_chain_tag_address_stepper_unit
// source-chain dma tag sequencer: addresses, return stack and tag stepping
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_ready / in_data): one command beat per handshake
//   out channel (out_valid / out_ready / out_data): one result beat for each
//     command beat, in order: memory address, tag address and stack depth
//     after the command, plus the end-of-transfer flag of a tag step
//   cfg_we / cfg_data: writes call_ret_enabled; the user must write it only
//     while idle, the block does not enforce this
// path: input register, then the result register loaded with the new state
// one beat per cycle while out_ready is high; the channel state is read and
//   written in the same cycle the result register loads; next command sees it
// reset (rst, synchronous): addresses, slots and depth go to zero,
//   call_ret_enabled to one, both registers empty
// stall: while out_ready is low a full result register holds its beat, the
//   input register keeps one more command and in_ready drops after that
// ----------------------------------------------------------------------------
module dma_chain_tag_address_stepper_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcts_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dcts_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_data
);

  logic                  stage_valid;
  dcts_pkg::in_beat_t    stage_data;
  logic                  fire;
  logic                  call_ret_enabled;
  dcts_pkg::chan_state_t chan;
  dcts_pkg::chan_state_t chan_next;
  logic                  end_next;

  // a staged command moves on when the result register is free or draining
  assign fire = stage_valid && (!out_valid || out_ready);

  dcts_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .take        (fire),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  dcts_tag_step u_tag_step (
    .beat             (stage_data),
    .cur              (chan),
    .call_ret_enabled (call_ret_enabled),
    .nxt              (chan_next),
    .end_transfer     (end_next)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      call_ret_enabled <= 1'b1;
    end else if (cfg_we) begin
      call_ret_enabled <= cfg_data;
    end
  end

  // channel state, updated once per command
  always_ff @(posedge clk) begin
    if (rst) begin
      chan <= '0;
    end else if (fire) begin
      chan <= chan_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_data.memory_address <= chan_next.mem_addr;
      out_data.tag_address    <= chan_next.next_tag_addr;
      out_data.stack_depth    <= chan_next.depth_count;
      out_data.end_transfer   <= end_next;
    end
  end

  // only tag steps may end a transfer
  a_end_only_on_step: assert property (@(posedge clk) disable iff (rst)
    fire && stage_data.command != dcts_pkg::CMD_TAG_STEP |=> !out_data.end_transfer)
    else $error("end_transfer set by a non tag-step command");

  // reported state tracks the held channel state
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_data.memory_address == chan.mem_addr &&
             out_data.tag_address == chan.next_tag_addr &&
             out_data.stack_depth == chan.depth_count)
    else $error("result beat differs from channel state");

  // a successful call from an empty stack pushes one entry
  a_call_push: assert property (@(posedge clk) disable iff (rst)
    fire && stage_data.command == dcts_pkg::CMD_TAG_STEP &&
    stage_data.tag_id == dcts_pkg::KIND_CALL && call_ret_enabled &&
    chan.depth_count == 2'd0 |=> chan.depth_count == 2'd1 && !out_data.end_transfer)
    else $error("call push from empty stack wrong");

  // a successful ret from depth one clears slot zero
  a_ret_clears: assert property (@(posedge clk) disable iff (rst)
    fire && stage_data.command == dcts_pkg::CMD_TAG_STEP &&
    stage_data.tag_id == dcts_pkg::KIND_RET && call_ret_enabled &&
    chan.depth_count == 2'd1 |=> chan.return_slot0 == 32'd0 && chan.depth_count == 2'd0)
    else $error("ret did not pop slot zero");

  // a new result appears only after a staged command moved on
  a_result_from_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire))
    else $error("result beat without a command");

endmodule

FILE: hdl/dcts_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcts_in_stage
// input register for command beats, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module dcts_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dcts_pkg::in_beat_t in_data,
  input  logic              take,
  output logic              stage_valid,
  output dcts_pkg::in_beat_t stage_data
);

  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

endmodule

FILE: hdl/dcts_tag_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcts_tag_step
// next channel state for one command beat
// ----------------------------------------------------------------------------
module dcts_tag_step (
  input  dcts_pkg::in_beat_t    beat,
  input  dcts_pkg::chan_state_t cur,
  input  logic                  call_ret_enabled,
  output dcts_pkg::chan_state_t nxt,
  output logic                  end_transfer
);

  logic [31:0] tag_plus;
  logic [31:0] call_return;

  assign tag_plus    = cur.next_tag_addr + dcts_pkg::QW_BYTES;
  // address after the data that follows a call tag
  assign call_return = tag_plus + {12'd0, beat.quadword_count, 4'd0};

  always_comb begin
    nxt          = cur;
    end_transfer = 1'b0;
    case (beat.command)
      dcts_pkg::CMD_WRITE_MADR: begin
        nxt.mem_addr = beat.write_value;
      end
      dcts_pkg::CMD_WRITE_TADR: begin
        nxt.next_tag_addr = beat.write_value;
      end
      dcts_pkg::CMD_WRITE_DEPTH: begin
        nxt.depth_count = beat.write_value[1:0];
      end
      dcts_pkg::CMD_DATA_DONE: begin
        if (beat.channel_started && beat.channel_mode == dcts_pkg::MODE_CHAIN &&
            beat.last_tag_id == dcts_pkg::KIND_CNT) begin
          nxt.next_tag_addr = cur.mem_addr;
        end
      end
      dcts_pkg::CMD_TAG_STEP: begin
        case (beat.tag_id)
          dcts_pkg::KIND_REFE: begin
            nxt.next_tag_addr = tag_plus;
            end_transfer      = 1'b1;
          end
          dcts_pkg::KIND_CNT: begin
            nxt.next_tag_addr = tag_plus;
            nxt.mem_addr      = tag_plus;
          end
          dcts_pkg::KIND_NEXT: begin
            nxt.mem_addr      = tag_plus;
            nxt.next_tag_addr = cur.mem_addr;
          end
          dcts_pkg::KIND_REF, dcts_pkg::KIND_REFS: begin
            nxt.next_tag_addr = tag_plus;
          end
          dcts_pkg::KIND_CALL: begin
            if (!call_ret_enabled) begin
              end_transfer = 1'b1;
            end else begin
              nxt.mem_addr = tag_plus;
              if (cur.depth_count == 2'd0) begin
                nxt.return_slot0  = call_return;
                nxt.depth_count   = 2'd1;
                nxt.next_tag_addr = cur.mem_addr;
              end else if (cur.depth_count == 2'd1) begin
                nxt.return_slot1  = call_return;
                nxt.depth_count   = 2'd2;
                nxt.next_tag_addr = cur.mem_addr;
              end else begin
                // stack full
                end_transfer = 1'b1;
              end
            end
          end
          dcts_pkg::KIND_RET: begin
            if (!call_ret_enabled) begin
              end_transfer = 1'b1;
            end else begin
              nxt.mem_addr = tag_plus;
              if (cur.depth_count == 2'd2) begin
                nxt.next_tag_addr = cur.return_slot1;
                nxt.return_slot1  = 32'd0;
                nxt.depth_count   = 2'd1;
              end else if (cur.depth_count == 2'd1) begin
                nxt.next_tag_addr = cur.return_slot0;
                nxt.return_slot0  = 32'd0;
                nxt.depth_count   = 2'd0;
              end else begin
                // stack empty
                end_transfer = 1'b1;
              end
            end
          end
          default: begin
            // end tag
            nxt.mem_addr = tag_plus;
            end_transfer = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule
